// ----- hw/rtl/sabp_pkg.sv -----
// ---------------------------------------------------------------------------
// sabp_pkg
// Shared types and constants of the SMILES atom and bond parser.
// ---------------------------------------------------------------------------
package sabp_pkg;

    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_O      = 8'h4F;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;
    localparam logic [7:0] CHAR_SQ_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQ_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_BR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_BR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_DIGIT_ONE = 8'h31;
    localparam int         DIGIT_BASE   = 48;

    localparam logic [1:0] ELEM_C = 2'd0;
    localparam logic [1:0] ELEM_N = 2'd1;
    localparam logic [1:0] ELEM_O = 2'd2;

    localparam logic [1:0] ORDER_RING   = 2'd0;
    localparam logic [1:0] ORDER_SINGLE = 2'd1;
    localparam logic [1:0] ORDER_DOUBLE = 2'd2;

    typedef enum logic [1:0] {
        EV_ATOM     = 2'd0,
        EV_BOND     = 2'd1,
        EV_OVERFLOW = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       start_of_string;
    } in_item_t;

    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  atom_number;
        logic [1:0]  element_code;
        logic [7:0]  bond_from;
        logic [7:0]  bond_to;
        logic [1:0]  bond_order;
        logic        last_of_run;
    } result_t;

    localparam result_t RESULT_ZERO = '{
        kind: EV_ATOM, atom_number: 8'd0, element_code: 2'd0,
        bond_from: 8'd0, bond_to: 8'd0, bond_order: 2'd0, last_of_run: 1'b0
    };

endpackage

// ----- hw/rtl/sabp_in_stage.sv -----
// ---------------------------------------------------------------------------
// sabp_in_stage
// Input register: holds one character request until the parser takes it.
// ---------------------------------------------------------------------------
module sabp_in_stage
    import sabp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- hw/rtl/sabp_parse_core.sv -----
// ---------------------------------------------------------------------------
// sabp_parse_core
// Parse state and single-pass decode of one character into up to two results.
// ---------------------------------------------------------------------------
module sabp_parse_core
    import sabp_pkg::*;
#(
    parameter int MAX_ATOMS  = 256,
    parameter int RING_SLOTS = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_item_t   item,
    output logic [1:0] res_count,
    output result_t    res0,
    output result_t    res1
);

    localparam int CW = $clog2(MAX_ATOMS + 1);
    localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [7:0] RING_LAST = 8'(DIGIT_BASE + RING_SLOTS);
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_ATOMS);

    logic [CW-1:0]         atom_count_reg, atom_count_next, cur_count;
    logic [7:0]            source_atom_reg, source_atom_next, cur_source;
    logic                  source_valid_reg, source_valid_next, cur_source_valid;
    logic [7:0]            branch_atom_reg, branch_atom_next, cur_branch;
    logic                  branch_pending_reg, branch_pending_next, cur_branch_pending;
    logic                  inside_square_reg, inside_square_next, cur_inside;
    logic [1:0]            pending_order_reg, pending_order_next, cur_order;
    logic [RING_SLOTS-1:0] ring_valid_reg, ring_valid_next, cur_ring_valid;
    logic [7:0]            ring_atom_reg [RING_SLOTS];
    logic [7:0]            ring_atom_next [RING_SLOTS];

    logic [7:0]    c;
    logic          is_atom;
    logic [1:0]    elem;
    logic [7:0]    new_atom;
    logic [7:0]    last_atom;
    logic [SW-1:0] slot;

    assign c         = item.char_code;
    assign is_atom   = (c == CHAR_C) || (c == CHAR_N) || (c == CHAR_O);
    assign elem      = (c == CHAR_C) ? ELEM_C : ((c == CHAR_N) ? ELEM_N : ELEM_O);
    assign slot      = SW'(c - CHAR_DIGIT_ONE);

    // start flag clears state ahead of this character
    always_comb
    begin
        if (item.start_of_string)
        begin
            cur_count          = '0;
            cur_source         = 8'd0;
            cur_source_valid   = 1'b0;
            cur_branch         = 8'd0;
            cur_branch_pending = 1'b0;
            cur_inside         = 1'b0;
            cur_order          = ORDER_SINGLE;
            cur_ring_valid     = '0;
        end
        else
        begin
            cur_count          = atom_count_reg;
            cur_source         = source_atom_reg;
            cur_source_valid   = source_valid_reg;
            cur_branch         = branch_atom_reg;
            cur_branch_pending = branch_pending_reg;
            cur_inside         = inside_square_reg;
            cur_order          = pending_order_reg;
            cur_ring_valid     = ring_valid_reg;
        end
    end

    assign new_atom  = 8'(cur_count);
    assign last_atom = 8'(cur_count - 1'b1);

    always_comb
    begin
        atom_count_next     = atom_count_reg;
        source_atom_next    = source_atom_reg;
        source_valid_next   = source_valid_reg;
        branch_atom_next    = branch_atom_reg;
        branch_pending_next = branch_pending_reg;
        inside_square_next  = inside_square_reg;
        pending_order_next  = pending_order_reg;
        ring_valid_next     = ring_valid_reg;
        ring_atom_next      = ring_atom_reg;
        res_count           = 2'd0;
        res0                = RESULT_ZERO;
        res1                = RESULT_ZERO;

        if (fire)
        begin
            atom_count_next     = cur_count;
            source_atom_next    = cur_source;
            source_valid_next   = cur_source_valid;
            branch_atom_next    = cur_branch;
            branch_pending_next = cur_branch_pending;
            inside_square_next  = cur_inside;
            pending_order_next  = cur_order;
            ring_valid_next     = cur_ring_valid;

            if (is_atom)
            begin
                if (cur_count == COUNT_FULL)
                begin
                    res_count         = 2'd1;
                    res0.kind         = EV_OVERFLOW;
                    res0.element_code = elem;
                end
                else
                begin
                    atom_count_next   = cur_count + 1'b1;
                    res0.kind         = EV_ATOM;
                    res0.atom_number  = new_atom;
                    res0.element_code = elem;
                    if (cur_source_valid)
                    begin
                        res_count           = 2'd2;
                        res1.kind           = EV_BOND;
                        res1.bond_from      = cur_branch_pending ? cur_branch : cur_source;
                        res1.bond_to        = new_atom;
                        res1.bond_order     = cur_order;
                        branch_pending_next = 1'b0;
                        pending_order_next  = ORDER_SINGLE;
                    end
                    else
                    begin
                        res_count = 2'd1;
                    end
                    source_atom_next  = new_atom;
                    source_valid_next = 1'b1;
                end
            end
            else if (c == CHAR_EQ)
            begin
                pending_order_next = ORDER_DOUBLE;
            end
            else if (c == CHAR_SQ_OPEN)
            begin
                inside_square_next = 1'b1;
            end
            else if (c == CHAR_SQ_CLOSE)
            begin
                inside_square_next = 1'b0;
            end
            else if (c == CHAR_BR_OPEN)
            begin
                if (cur_count != '0)
                begin
                    branch_atom_next = last_atom;
                end
            end
            else if (c == CHAR_BR_CLOSE)
            begin
                branch_pending_next = 1'b1;
            end
            else if (c >= CHAR_DIGIT_ONE && c <= RING_LAST && !cur_inside)
            begin
                if (!cur_ring_valid[slot])
                begin
                    if (cur_count != '0)
                    begin
                        ring_valid_next[slot] = 1'b1;
                        ring_atom_next[slot]  = last_atom;
                    end
                end
                else
                begin
                    res_count             = 2'd1;
                    res0.kind             = EV_BOND;
                    res0.bond_from        = ring_atom_reg[slot];
                    res0.bond_to          = cur_source;
                    res0.bond_order       = ORDER_RING;
                    ring_valid_next[slot] = 1'b0;
                end
            end
        end

        res0.last_of_run = (res_count == 2'd1);
        res1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atom_count_reg     <= '0;
            source_atom_reg    <= 8'd0;
            source_valid_reg   <= 1'b0;
            branch_atom_reg    <= 8'd0;
            branch_pending_reg <= 1'b0;
            inside_square_reg  <= 1'b0;
            pending_order_reg  <= ORDER_SINGLE;
            ring_valid_reg     <= '0;
        end
        else
        begin
            atom_count_reg     <= atom_count_next;
            source_atom_reg    <= source_atom_next;
            source_valid_reg   <= source_valid_next;
            branch_atom_reg    <= branch_atom_next;
            branch_pending_reg <= branch_pending_next;
            inside_square_reg  <= inside_square_next;
            pending_order_reg  <= pending_order_next;
            ring_valid_reg     <= ring_valid_next;
        end
    end

    // slot atoms are only read behind their valid bit
    always_ff @(posedge clk)
    begin
        ring_atom_reg <= ring_atom_next;
    end

endmodule

// ----- hw/rtl/sabp_out_buf.sv -----
// ---------------------------------------------------------------------------
// sabp_out_buf
// Two-entry result register; shifts out results of one character in order.
// ---------------------------------------------------------------------------
module sabp_out_buf
    import sabp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [1:0] load_count,
    input  result_t    load0,
    input  result_t    load1,
    output logic       can_load,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    m_result
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    entry0_reg;
    result_t    entry1_reg;
    logic       pop;

    assign m_valid  = (count_reg != 2'd0);
    assign m_result = entry0_reg;
    assign pop      = m_valid && m_ready;
    assign can_load = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready);

    always_comb
    begin
        count_next = count_reg;
        if (pop)
        begin
            count_next = count_reg - 2'd1;
        end
        if (load)
        begin
            count_next = load_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry0_reg <= load0;
            entry1_reg <= load1;
        end
        else if (pop)
        begin
            entry0_reg <= entry1_reg;
        end
    end

endmodule

// ----- hw/rtl/smiles_atom_bond_parser.sv -----
// ---------------------------------------------------------------------------
// smiles_atom_bond_parser
// Parses a SMILES character stream into atom, bond and overflow events.
//
// Channel  Dir  tdata (low bit up)                              tuser          tlast
// s_axis   in   char_code[7:0]                                  start_of_string  -
// m_axis   out  atom_number[7:0] element_code[9:8]              event_kind[1:0]  last_of_run
//               bond_from[17:10] bond_to[25:18] bond_order[27:26], zero fill [31:28]
//
// Each character request is decoded in one pass between the input register and a
// two-entry result register. With m_axis ready, one request per cycle is taken;
// atom characters that also bond give two results and hold back the next request
// until these leave. Other atoms, overflows and ring closures give one, the rest
// none. Results pass the input, then the result register. Reset clears parse state;
// no clearing pass. m_axis stalls back up through the result register to s_axis_tready.
// ---------------------------------------------------------------------------
module smiles_atom_bond_parser
    import sabp_pkg::*;
#(
    parameter int MAX_ATOMS  = 256,
    parameter int RING_SLOTS = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic [0:0]  s_axis_tuser,   // start_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // atom_number, element_code, bond_from, bond_to, bond_order
    output logic [1:0]  m_axis_tuser,   // event_kind
    output logic        m_axis_tlast
);

    in_item_t   s_item;
    in_item_t   item;
    logic       item_valid;
    logic       can_load;
    logic       fire;
    logic [1:0] res_count;
    result_t    res0;
    result_t    res1;
    result_t    m_result;

    assign s_item.char_code       = s_axis_tdata;
    assign s_item.start_of_string = s_axis_tuser[0];
    assign fire                   = item_valid && can_load;

    sabp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sabp_parse_core #(
        .MAX_ATOMS  (MAX_ATOMS),
        .RING_SLOTS (RING_SLOTS)
    ) u_parse_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    sabp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .load_count (res_count),
        .load0      (res0),
        .load1      (res1),
        .can_load   (can_load),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (m_result)
    );

    assign m_axis_tdata = {4'd0, m_result.bond_order, m_result.bond_to, m_result.bond_from,
                           m_result.element_code, m_result.atom_number};
    assign m_axis_tuser = m_result.kind;
    assign m_axis_tlast = m_result.last_of_run;

endmodule

// ----- tb/sv/smiles_atom_bond_parser_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// smiles_atom_bond_parser_tb
// Streams SMILES characters into the parser and checks every atom, bond and
// overflow event against an in-bench parse of the same characters. A short
// directed table comes first, then one long chain that runs past the atom
// capacity, then random molecules with byte noise. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module smiles_atom_bond_parser_tb
    import sabp_pkg::*;
();

    localparam int MAX_ATOMS   = 256;
    localparam int RING_SLOTS  = 2;
    localparam int ITEMS       = 1050;
    localparam int LIMIT       = 200000;
    localparam int QUIET_LO    = 1000;
    localparam int QUIET_HI    = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int DIR_ROWS    = 24;
    localparam logic [7:0] CHAR_H = 8'h48;

    // how a request's results are known
    typedef enum logic [1:0] {
        CHK_PRED,   // from the in-bench parse
        CHK_NONE,   // no result
        CHK_ROOT    // single atom event, atom 0
    } chk_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       sos;
        chk_t       chk;
        logic [1:0] elem;
    } char_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // char_code
    logic [0:0]  s_axis_tuser = 1'b0;   // start_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // atom_number, element_code, bond_from, bond_to,
                                        // bond_order, zero fill
    logic [1:0]  m_axis_tuser;          // event_kind
    logic        m_axis_tlast;

    // parse state
    logic [8:0] n_atoms;
    logic [7:0] src_atom;
    logic       src_ok;
    logic [7:0] br_atom;
    logic       br_pend;
    logic       in_sq;
    logic [1:0] next_order;
    logic [8:0] rings [RING_SLOTS];

    char_req_t char_reqs [$];
    result_t   pending_events [$];
    int        req_idx = 0;
    int        cycles = 0;
    int        mismatches = 0;

    char_req_t dir_tbl [DIR_ROWS] = '{
        '{CHAR_C,        1'b1, CHK_ROOT, ELEM_C},
        '{CHAR_H,        1'b0, CHK_NONE, ELEM_C},
        '{CHAR_EQ,       1'b0, CHK_NONE, ELEM_C},
        '{CHAR_O,        1'b0, CHK_PRED, ELEM_C},   // double bond
        '{CHAR_BR_OPEN,  1'b0, CHK_NONE, ELEM_C},
        '{CHAR_N,        1'b0, CHK_PRED, ELEM_C},
        '{CHAR_BR_CLOSE, 1'b0, CHK_NONE, ELEM_C},
        '{CHAR_DIGIT_ONE, 1'b0, CHK_NONE, ELEM_C},  // ring open
        '{CHAR_C,        1'b0, CHK_PRED, ELEM_C},   // bond from branch atom
        '{CHAR_DIGIT_ONE, 1'b0, CHK_PRED, ELEM_C},  // ring close
        '{CHAR_SQ_OPEN,  1'b0, CHK_NONE, ELEM_C},
        '{CHAR_N,        1'b0, CHK_PRED, ELEM_C},   // atom in brackets
        '{8'h32,         1'b0, CHK_NONE, ELEM_C},   // ring digit in brackets
        '{CHAR_SQ_CLOSE, 1'b0, CHK_NONE, ELEM_C},
        '{8'h33,         1'b0, CHK_NONE, ELEM_C},
        '{8'h30,         1'b0, CHK_NONE, ELEM_C},
        '{8'hFF,         1'b0, CHK_NONE, ELEM_C},
        '{8'h00,         1'b0, CHK_NONE, ELEM_C},
        '{CHAR_BR_CLOSE, 1'b1, CHK_NONE, ELEM_C},   // close without open
        '{8'h32,         1'b0, CHK_NONE, ELEM_C},   // ring digit, no atom yet
        '{CHAR_BR_OPEN,  1'b0, CHK_NONE, ELEM_C},   // open, no atom yet
        '{CHAR_O,        1'b0, CHK_ROOT, ELEM_O},
        '{CHAR_C,        1'b0, CHK_PRED, ELEM_C},   // bond from branch atom 0
        '{CHAR_N,        1'b1, CHK_ROOT, ELEM_N}
    };

    smiles_atom_bond_parser #(
        .MAX_ATOMS  (MAX_ATOMS),
        .RING_SLOTS (RING_SLOTS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    task automatic add_req(input char_req_t req);
        char_reqs = {char_reqs, req};
    endtask

    task automatic add_event(input result_t ev);
        pending_events = {pending_events, ev};
    endtask

    task automatic clear_parse();
        n_atoms    = 9'd0;
        src_atom   = 8'd0;
        src_ok     = 1'b0;
        br_atom    = 8'd0;
        br_pend    = 1'b0;
        in_sq      = 1'b0;
        next_order = ORDER_SINGLE;
        for (int i = 0; i < RING_SLOTS; i++)
            rings[i] = 9'd0;
    endtask

    task automatic parse_char(input logic [7:0] ch, input logic sos,
                              output result_t ev0, output result_t ev1, output int n);
        result_t    ev [2];
        logic [1:0] elem;
        logic [7:0] a;
        logic [8:0] prev;
        int         s;
        ev[0] = RESULT_ZERO;
        ev[1] = RESULT_ZERO;
        n = 0;
        if (sos)
            clear_parse();
        prev = n_atoms - 9'd1;
        if (ch == CHAR_C || ch == CHAR_N || ch == CHAR_O)
        begin
            elem = (ch == CHAR_C) ? ELEM_C : (ch == CHAR_N) ? ELEM_N : ELEM_O;
            if (n_atoms >= MAX_ATOMS)
            begin
                ev[0].kind = EV_OVERFLOW;
                ev[0].element_code = elem;
                n = 1;
            end
            else
            begin
                a = n_atoms[7:0];
                n_atoms = n_atoms + 9'd1;
                ev[0].kind = EV_ATOM;
                ev[0].atom_number = a;
                ev[0].element_code = elem;
                n = 1;
                if (src_ok)
                begin
                    ev[1].kind = EV_BOND;
                    ev[1].bond_from = br_pend ? br_atom : src_atom;
                    ev[1].bond_to = a;
                    ev[1].bond_order = next_order;
                    n = 2;
                    br_pend = 1'b0;
                    next_order = ORDER_SINGLE;
                end
                src_atom = a;
                src_ok = 1'b1;
            end
        end
        else if (ch == CHAR_EQ)
            next_order = ORDER_DOUBLE;
        else if (ch == CHAR_SQ_OPEN)
            in_sq = 1'b1;
        else if (ch == CHAR_SQ_CLOSE)
            in_sq = 1'b0;
        else if (ch == CHAR_BR_OPEN)
        begin
            if (n_atoms != 9'd0)
                br_atom = prev[7:0];
        end
        else if (ch == CHAR_BR_CLOSE)
            br_pend = 1'b1;
        else if (int'(ch) >= DIGIT_BASE + 1 && int'(ch) <= DIGIT_BASE + RING_SLOTS)
        begin
            if (!in_sq)
            begin
                s = int'(ch) - (DIGIT_BASE + 1);
                if (!rings[s][8])
                begin
                    if (n_atoms != 9'd0)
                        rings[s] = {1'b1, prev[7:0]};
                end
                else
                begin
                    ev[0].kind = EV_BOND;
                    ev[0].bond_from = rings[s][7:0];
                    ev[0].bond_to = src_atom;
                    ev[0].bond_order = ORDER_RING;
                    n = 1;
                    rings[s] = 9'd0;
                end
            end
        end
        if (n > 0)
            ev[n - 1].last_of_run = 1'b1;
        ev0 = ev[0];
        ev1 = ev[1];
    endtask

    function automatic logic [7:0] pick_char(int atom_pct);
        int r;
        int d;
        r = $urandom_range(99);
        if (r < atom_pct)
        begin
            case ($urandom_range(2))
                0: return CHAR_C;
                1: return CHAR_N;
                default: return CHAR_O;
            endcase
        end
        r = $urandom_range(59);
        if (r < 8)  return CHAR_EQ;
        if (r < 16) return CHAR_BR_OPEN;
        if (r < 24) return CHAR_BR_CLOSE;
        if (r < 28) return CHAR_SQ_OPEN;
        if (r < 36) return CHAR_SQ_CLOSE;
        if (r < 50) return CHAR_DIGIT_ONE + 8'($urandom_range(RING_SLOTS - 1));
        if (r < 53)
        begin
            d = $urandom_range(7);
            d = (d == 0) ? 0 : d + 2;
            return 8'(DIGIT_BASE + d);
        end
        if (r < 56) return CHAR_H;
        return 8'($urandom_range(255));
    endfunction

    task automatic add_molecule(input int len, input int atom_pct, input logic restarts);
        char_req_t req;
        for (int i = 0; i < len; i++)
        begin
            req.ch   = (i == 0 && $urandom_range(3) != 0) ? CHAR_C : pick_char(atom_pct);
            req.sos  = (i == 0) || (restarts && ($urandom_range(99) == 0));
            req.chk  = CHK_PRED;
            req.elem = ELEM_C;
            add_req(req);
        end
    endtask

    function automatic logic idle_now();
        return (cycles < QUIET_LO || cycles >= QUIET_HI) && ($urandom_range(99) < 6);
    endfunction

    function automatic string ev_str(result_t e);
        return $sformatf("kind=%0d atom=%0d elem=%0d from=%0d to=%0d order=%0d last=%0d",
                         e.kind, e.atom_number, e.element_code, e.bond_from, e.bond_to,
                         e.bond_order, e.last_of_run);
    endfunction

    // character requests
    always @(posedge clk)
    begin : drive_chars
        result_t   ev0;
        result_t   ev1;
        int        n;
        char_req_t req;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                req = char_reqs[req_idx];
                parse_char(req.ch, req.sos, ev0, ev1, n);
                case (req.chk)
                    CHK_PRED:
                    begin
                        if (n > 0) add_event(ev0);
                        if (n > 1) add_event(ev1);
                    end
                    CHK_NONE: ;
                    default:
                    begin
                        ev0 = RESULT_ZERO;
                        ev0.kind = EV_ATOM;
                        ev0.element_code = req.elem;
                        ev0.last_of_run = 1'b1;
                        add_event(ev0);
                    end
                endcase
                req_idx++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_idx < char_reqs.size() && !idle_now())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= char_reqs[req_idx].ch;
                    s_axis_tuser  <= char_reqs[req_idx].sos;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result checking
    always @(posedge clk)
    begin : check_events
        result_t got;
        result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind         = event_kind_t'(m_axis_tuser);
                got.atom_number  = m_axis_tdata[7:0];
                got.element_code = m_axis_tdata[9:8];
                got.bond_from    = m_axis_tdata[17:10];
                got.bond_to      = m_axis_tdata[25:18];
                got.bond_order   = m_axis_tdata[27:26];
                got.last_of_run  = m_axis_tlast;
                if (pending_events.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected event: %s", ev_str(got));
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.kind !== want.kind || got.atom_number !== want.atom_number
                        || got.element_code !== want.element_code
                        || got.bond_from !== want.bond_from || got.bond_to !== want.bond_to
                        || got.bond_order !== want.bond_order
                        || got.last_of_run !== want.last_of_run)
                    begin
                        if (mismatches < 10)
                            $display("mismatch: expected %s, got %s", ev_str(want),
                                     ev_str(got));
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        clear_parse();
        for (int i = 0; i < DIR_ROWS; i++)
            add_req(dir_tbl[i]);
        add_molecule(330, 92, 1'b0);   // long chain past capacity
        while (char_reqs.size() < ITEMS)
            add_molecule($urandom_range(3, 24), 45, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (req_idx < char_reqs.size() || pending_events.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
